/* rtl/hxl_pkg.sv */
package hxl_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_END      = 2'd1,
    KIND_FORMAT   = 2'd2,
    KIND_CHECKSUM = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_COUNT      = 4'd1,
    PH_ADDRESS    = 4'd2,
    PH_TYPE       = 4'd3,
    PH_DATA       = 4'd4,
    PH_CHECK      = 4'd5,
    PH_LINE_END   = 4'd6
  } phase_e;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_START   = 8'h03;
  localparam logic [7:0] SEG_COUNT   = 8'h02;

  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam int unsigned AddrW = 21;
  localparam int unsigned SegW  = 20;

  // classified character passed from front to back
  typedef struct packed {
    logic       colon;
    logic       newline;
    logic       hex;
    logic [3:0] nibble;
  } char_class_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } result_t;

endpackage

/* rtl/hxl_fifo.sv */
module hxl_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/hxl_front.sv */
module hxl_front (
  input  logic                [7:0] character_i,
  output hxl_pkg::char_class_t      cls_o
);

  import hxl_pkg::*;

  always_comb begin
    cls_o.colon   = (character_i == CHAR_COLON);
    cls_o.newline = (character_i == CHAR_NEWLINE);
    cls_o.hex     = 1'b1;
    cls_o.nibble  = character_i[3:0];
    if (character_i inside {[8'h30:8'h39]}) begin
      cls_o.nibble = character_i[3:0];
    end else if (character_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      // letters a-f and A-F share the low three bits
      cls_o.nibble = 4'(character_i[2:0] + 3'd1) + 4'd8;
    end else begin
      cls_o.hex = 1'b0;
    end
  end

endmodule

/* rtl/hxl_back.sv */
module hxl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hxl_pkg::char_class_t cls_i,
  input  logic                 avail_i,
  input  logic                 room_i,
  output logic                 take_o,
  output logic                 res_valid_o,
  output hxl_pkg::result_t     res_o
);

  import hxl_pkg::*;

  phase_e           phase_q, phase_d;
  logic [2:0]       nib_cnt_q, nib_cnt_d;
  logic [15:0]      acc_q, acc_d;
  logic [7:0]       left_q, left_d;
  logic [7:0]       rtype_q, rtype_d;
  logic [7:0]       sum_q, sum_d;
  logic [SegW-1:0]  seg_q, seg_d;
  logic [AddrW-1:0] naddr_q, naddr_d;
  logic             fin_q, fin_d;

  logic [15:0] acc_n;
  logic [2:0]  cnt_n;
  logic [2:0]  need;
  logic [7:0]  left_n;

  assign take_o = avail_i && room_i;
  assign acc_n  = {acc_q[11:0], cls_i.nibble};
  assign cnt_n  = nib_cnt_q + 3'd1;
  assign left_n = left_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    nib_cnt_d   = nib_cnt_q;
    acc_d       = acc_q;
    left_d      = left_q;
    rtype_d     = rtype_q;
    sum_d       = sum_q;
    seg_d       = seg_q;
    naddr_d     = naddr_q;
    fin_d       = fin_q;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_FORMAT;
    res_o.addr  = '0;
    res_o.data  = '0;
    need = ((phase_q == PH_ADDRESS) || ((phase_q == PH_DATA) && (rtype_q == REC_SEGMENT)))
           ? 3'd4 : 3'd2;

    if (take_o && !fin_q) begin
      case (phase_q)
        PH_LINE_START: begin
          if (!cls_i.colon) begin
            fin_d       = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_FORMAT;
          end else begin
            phase_d   = PH_COUNT;
            nib_cnt_d = '0;
            acc_d     = '0;
            sum_d     = '0;
          end
        end
        PH_LINE_END: begin
          if (cls_i.newline) begin
            phase_d = PH_LINE_START;
          end
        end
        PH_COUNT, PH_ADDRESS, PH_TYPE, PH_DATA, PH_CHECK: begin
          if (!cls_i.hex) begin
            fin_d       = 1'b1;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_FORMAT;
          end else if (cnt_n < need) begin
            acc_d     = acc_n;
            nib_cnt_d = cnt_n;
          end else begin
            // field complete
            acc_d     = '0;
            nib_cnt_d = '0;
            case (phase_q)
              PH_COUNT: begin
                left_d  = acc_n[7:0];
                sum_d   = acc_n[7:0];
                phase_d = PH_ADDRESS;
              end
              PH_ADDRESS: begin
                sum_d   = sum_q + acc_n[15:8] + acc_n[7:0];
                naddr_d = AddrW'(acc_n);
                phase_d = PH_TYPE;
              end
              PH_TYPE: begin
                rtype_d = acc_n[7:0];
                sum_d   = sum_q + acc_n[7:0];
                case (acc_n[7:0])
                  REC_DATA: begin
                    naddr_d = AddrW'(seg_q) + naddr_q;
                    phase_d = (left_q != '0) ? PH_DATA : PH_CHECK;
                  end
                  REC_EOF: begin
                    fin_d       = 1'b1;
                    res_valid_o = 1'b1;
                    res_o.kind  = KIND_END;
                  end
                  REC_SEGMENT: begin
                    if (left_q != SEG_COUNT) begin
                      fin_d       = 1'b1;
                      res_valid_o = 1'b1;
                      res_o.kind  = KIND_FORMAT;
                    end else begin
                      phase_d = PH_DATA;
                    end
                  end
                  REC_START: begin
                    phase_d = (left_q != '0) ? PH_DATA : PH_CHECK;
                  end
                  default: begin
                    fin_d       = 1'b1;
                    res_valid_o = 1'b1;
                    res_o.kind  = KIND_FORMAT;
                  end
                endcase
              end
              PH_DATA: begin
                if (rtype_q == REC_SEGMENT) begin
                  sum_d   = sum_q + acc_n[15:8] + acc_n[7:0];
                  seg_d   = {acc_n, 4'h0};
                  left_d  = '0;
                  phase_d = PH_CHECK;
                end else begin
                  sum_d  = sum_q + acc_n[7:0];
                  left_d = left_n;
                  if (left_n == '0) begin
                    phase_d = PH_CHECK;
                  end
                  if (rtype_q == REC_DATA) begin
                    res_valid_o = 1'b1;
                    res_o.kind  = KIND_WRITE;
                    res_o.addr  = naddr_q;
                    res_o.data  = acc_n[7:0];
                    naddr_d     = naddr_q + 1'b1;
                  end
                end
              end
              default: begin
                // checksum byte
                if ((sum_q + acc_n[7:0]) != 8'h00) begin
                  fin_d       = 1'b1;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_CHECKSUM;
                end else begin
                  phase_d = PH_LINE_END;
                end
              end
            endcase
          end
        end
        default: begin
          fin_d       = 1'b1;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_FORMAT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LINE_START;
      nib_cnt_q <= '0;
      acc_q     <= '0;
      left_q    <= '0;
      rtype_q   <= '0;
      sum_q     <= '0;
      seg_q     <= '0;
      naddr_q   <= '0;
      fin_q     <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      nib_cnt_q <= nib_cnt_d;
      acc_q     <= acc_d;
      left_q    <= left_d;
      rtype_q   <= rtype_d;
      sum_q     <= sum_d;
      seg_q     <= seg_d;
      naddr_q   <= naddr_d;
      fin_q     <= fin_d;
    end
  end

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |=> fin_q)
    else $error("stop flag cleared without reset");

  a_no_res_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !res_valid_o)
    else $error("result produced after stop");

  a_stop_sets_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind != KIND_WRITE)) |=> fin_q)
    else $error("end or error result did not stop the parser");

  a_stop_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind != KIND_WRITE)) |-> (res_o.addr == '0 && res_o.data == '0))
    else $error("non-write result carries payload");

endmodule

/* rtl/hex_record_loader.sv */
// hex record loader: parses an intel hex text stream fed one ascii character per beat and
// produces memory write beats (segment base plus record address, one per data byte), an end
// beat on an end-of-file record, or a format or checksum error beat; end and errors are
// sticky until reset and later characters are dropped silently. the block takes one
// character per cycle while the result queue has room: a classifying front stage writes
// each accepted character into a short queue, and the record parser state machine behind
// it handles one character per cycle unless a full result queue holds it; each result is
// registered in the result queue and shown on the result ports from there. both queues are
// QueueDepth beats deep; full rises only when the parser is held by a full result queue.
module hex_record_loader #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  character_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [20:0] write_address_o,
  output logic [7:0]  write_data_o
);

  import hxl_pkg::*;

  localparam int unsigned ClsW = $bits(char_class_t);
  localparam int unsigned ResW = $bits(result_t);

  char_class_t cls_in, cls_out;
  logic        mid_empty;
  logic        take;
  logic        res_valid;
  result_t     res, res_head;
  logic        out_full;

  // front: classify each character as it is accepted
  hxl_front u_front (
    .character_i(character_i),
    .cls_o      (cls_in)
  );

  // queue between front and parser
  hxl_fifo #(
    .Width(ClsW),
    .Depth(QueueDepth)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(cls_in),
    .full_o (full),
    .pop_i  (take),
    .rdata_o(cls_out),
    .empty_o(mid_empty)
  );

  // back: record parser, steps only while the result queue has room
  hxl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_i      (cls_out),
    .avail_i    (!mid_empty),
    .room_i     (!out_full),
    .take_o     (take),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // result queue decouples the parser from the consumer
  hxl_fifo #(
    .Width(ResW),
    .Depth(QueueDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .wdata_i(res),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(res_head),
    .empty_o(empty)
  );

  assign kind_o          = res_head.kind;
  assign write_address_o = res_head.addr;
  assign write_data_o    = res_head.data;

endmodule

/* test/hex_record_checker.sv */
`timescale 1ns / 1ps

module hex_record_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  character_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [1:0]  kind_i,
  input  logic [20:0] write_address_i,
  input  logic [7:0]  write_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  import hxl_pkg::*;

  // parser state as the block should hold it
  phase_e           parse_phase;
  logic [2:0]       digit_count;
  logic [15:0]      field_value;
  logic [7:0]       bytes_left;
  logic [7:0]       record_type;
  logic [7:0]       byte_sum;
  logic [SegW-1:0]  segment_base;
  logic [AddrW-1:0] write_pointer;
  logic             halted;

  result_t beats_due[$];

  // bit 4 flags a valid hex digit
  function automatic logic [4:0] decode_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic raise_stop(input kind_e kind);
    result_t beat;
    beat.kind = kind;
    beat.addr = '0;
    beat.data = '0;
    halted = 1'b1;
    beats_due.push_back(beat);
  endtask

  task automatic close_field(input logic [15:0] field);
    result_t    beat;
    logic [7:0] total;
    case (parse_phase)
      PH_COUNT: begin
        bytes_left  = field[7:0];
        byte_sum    = field[7:0];
        parse_phase = PH_ADDRESS;
      end
      PH_ADDRESS: begin
        byte_sum      = byte_sum + field[15:8] + field[7:0];
        write_pointer = AddrW'(field);
        parse_phase   = PH_TYPE;
      end
      PH_TYPE: begin
        record_type = field[7:0];
        byte_sum    = byte_sum + field[7:0];
        case (field[7:0])
          REC_DATA: begin
            write_pointer = {1'b0, segment_base} + write_pointer;
            parse_phase   = (bytes_left != 8'h00) ? PH_DATA : PH_CHECK;
          end
          REC_EOF: begin
            raise_stop(KIND_END);
          end
          REC_SEGMENT: begin
            if (bytes_left != SEG_COUNT) raise_stop(KIND_FORMAT);
            else parse_phase = PH_DATA;
          end
          REC_START: begin
            parse_phase = (bytes_left != 8'h00) ? PH_DATA : PH_CHECK;
          end
          default: begin
            raise_stop(KIND_FORMAT);
          end
        endcase
      end
      PH_DATA: begin
        if (record_type == REC_SEGMENT) begin
          byte_sum     = byte_sum + field[15:8] + field[7:0];
          segment_base = {field, 4'h0};
          bytes_left   = 8'h00;
          parse_phase  = PH_CHECK;
        end else begin
          byte_sum   = byte_sum + field[7:0];
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'h00) parse_phase = PH_CHECK;
          if (record_type == REC_DATA) begin
            beat.kind = KIND_WRITE;
            beat.addr = write_pointer;
            beat.data = field[7:0];
            beats_due.push_back(beat);
            write_pointer = write_pointer + 1'b1;
          end
        end
      end
      default: begin
        total = byte_sum + field[7:0];
        if (total != 8'h00) raise_stop(KIND_CHECKSUM);
        else parse_phase = PH_LINE_END;
      end
    endcase
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [4:0]  digit;
    logic [15:0] field;
    int unsigned need;
    if (halted) return;
    case (parse_phase)
      PH_LINE_START: begin
        if (c != CHAR_COLON) begin
          raise_stop(KIND_FORMAT);
        end else begin
          parse_phase = PH_COUNT;
          digit_count = '0;
          field_value = '0;
          byte_sum    = '0;
        end
      end
      PH_LINE_END: begin
        if (c == CHAR_NEWLINE) parse_phase = PH_LINE_START;
      end
      PH_COUNT, PH_ADDRESS, PH_TYPE, PH_DATA, PH_CHECK: begin
        digit = decode_digit(c);
        if (!digit[4]) begin
          raise_stop(KIND_FORMAT);
        end else begin
          field_value = {field_value[11:0], digit[3:0]};
          digit_count = digit_count + 3'd1;
          need = (parse_phase == PH_ADDRESS ||
                  (parse_phase == PH_DATA && record_type == REC_SEGMENT)) ? 4 : 2;
          if (digit_count >= need) begin
            field       = field_value;
            digit_count = '0;
            field_value = '0;
            close_field(field);
          end
        end
      end
      default: begin
        raise_stop(KIND_FORMAT);
      end
    endcase
  endtask

  task automatic compare_beat();
    result_t want;
    checked_o++;
    if (beats_due.size() == 0) begin
      error_count_o++;
      $display("%0t: unexpected result beat, expected none, got kind %0d addr %h data %h",
               $time, kind_i, write_address_i, write_data_i);
      return;
    end
    want = beats_due.pop_front();
    if (kind_i !== want.kind) begin
      error_count_o++;
      $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, kind_i);
    end
    if (write_address_i !== want.addr) begin
      error_count_o++;
      $display("%0t: write_address mismatch, expected %h, got %h",
               $time, want.addr, write_address_i);
    end
    if (write_data_i !== want.data) begin
      error_count_o++;
      $display("%0t: write_data mismatch, expected %h, got %h",
               $time, want.data, write_data_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_phase   = PH_LINE_START;
      digit_count   = '0;
      field_value   = '0;
      bytes_left    = '0;
      record_type   = '0;
      byte_sum      = '0;
      segment_base  = '0;
      write_pointer = '0;
      halted        = 1'b0;
      beats_due.delete();
      pending_o     = 0;
    end else begin
      if (pop_i && !empty_i) compare_beat();
      if (push_i && !full_i) parse_char(character_i);
      pending_o = beats_due.size();
    end
  end

endmodule

/* test/tb_hex_record_loader.sv */
`timescale 1ns / 1ps

module tb_hex_record_loader;
  import hxl_pkg::*;

  // stop feeding fresh records once this many characters went in
  localparam int unsigned CharTarget  = 1150;
  // worst case is roughly 2000 characters, so this is plenty
  localparam int unsigned CycleLimit  = 400000;
  // slack after the last expected result beat has been popped
  localparam int unsigned DrainCycles = 16;
  // characters thrown in after the stream has stopped
  localparam int unsigned AfterStop   = 16;
  localparam logic [7:0]  CHAR_CR     = 8'h0d;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  // character side
  logic        push      = 1'b0;
  logic        full;
  logic [7:0]  character = 8'h00;

  // result side
  logic        empty;
  logic        pop       = 1'b0;
  logic [1:0]  kind;
  logic [20:0] write_address;
  logic [7:0]  write_data;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;

  int unsigned cycle_count = 0;
  int unsigned chars_sent  = 0;
  int unsigned lines_sent  = 0;
  int unsigned stall_left  = 0;
  // random gaps on both sides, switched off for the tail of the run
  bit          idle_on     = 1'b1;
  string       closing     = "nothing";

  // text of the record being assembled, and its running byte sum
  logic [7:0]  line_buf[$];
  logic [7:0]  line_sum;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hex_record_loader dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .character_i     (character),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind),
    .write_address_o (write_address),
    .write_data_o    (write_data)
  );

  // watches both channels, predicts every result beat and compares
  hex_record_checker record_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push_i          (push),
    .full_i          (full),
    .character_i     (character),
    .empty_i         (empty),
    .pop_i           (pop),
    .kind_i          (kind),
    .write_address_i (write_address),
    .write_data_i    (write_data),
    .error_count_o   (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // hard stop in case the block hangs or swallows an expected beat
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: pop mostly high, with random stalls now and then
  always @(posedge clk) begin
    if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      pop <= 1'b1;
    end
  end

  // hex digit in random case, so both spellings get exercised
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    if ($urandom_range(0, 1) == 0) return "A" + 8'(n - 4'd10);
    return "a" + 8'(n - 4'd10);
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // mostly short records, some medium, and once in a while the full 255 bytes
  function automatic logic [7:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll == 0) return 8'hff;
    if (roll < 10) return 8'($urandom_range(17, 64));
    return 8'($urandom_range(0, 16));
  endfunction

  // one character beat: optional idle burst, then hold push until accepted
  task automatic send_char(input logic [7:0] c);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    character <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
    line_sum = line_sum + b;
  endtask

  // whole record text in line_buf; fill < 0 means random payload bytes
  task automatic build_record(input logic [7:0] rtype, input logic [7:0] count,
                              input logic [15:0] offset, input int fill,
                              input bit bad_sum);
    logic [7:0]  sum_byte;
    int unsigned junk;
    line_buf.delete();
    line_buf.push_back(CHAR_COLON);
    line_sum = 8'h00;
    add_byte(count);
    add_byte(offset[15:8]);
    add_byte(offset[7:0]);
    add_byte(rtype);
    repeat (count) add_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    sum_byte = 8'h00 - line_sum;
    // a bad checksum is off by anything but zero
    if (bad_sum) sum_byte = sum_byte + 8'($urandom_range(1, 255));
    add_byte(sum_byte);
    // trailing noise after the checksum: skipped by the block up to the newline, and the
    // only place in a well-formed record where bytes with the top bit set go in
    if ($urandom_range(0, 2) == 0) begin
      line_buf.push_back(CHAR_CR);
      junk = $urandom_range(0, 3);
      repeat (junk) line_buf.push_back(8'($urandom_range(0, 255)) | 8'h80);
      if ($urandom_range(0, 3) == 0) line_buf.push_back(8'h00);
    end
    line_buf.push_back(CHAR_NEWLINE);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
    lines_sent++;
  endtask

  initial begin
    int unsigned roll;
    int unsigned cut;
    logic [7:0]  count;
    logic [7:0]  stray;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: highest segment, then a write at the highest offset, so the
    // address runs past 64K without wrapping
    build_record(REC_SEGMENT, SEG_COUNT, 16'h0000, 8'hff, 1'b0);
    send_line();
    build_record(REC_DATA, 8'h01, 16'hffff, 8'hff, 1'b0);
    send_line();

    // random well-formed records: mostly data, with segment changes and
    // type 03 records mixed in (counts of zero included)
    while (chars_sent < CharTarget) begin
      idle_on = (chars_sent < CharTarget * 3 / 4);
      roll = $urandom_range(0, 19);
      if (roll < 14) begin
        build_record(REC_DATA, pick_count(), 16'($urandom), -1, 1'b0);
      end else if (roll < 17) begin
        build_record(REC_SEGMENT, SEG_COUNT, 16'($urandom), -1, 1'b0);
      end else begin
        build_record(REC_START, 8'($urandom_range(0, 8)), 16'($urandom), -1, 1'b0);
      end
      send_line();
    end
    idle_on = 1'b0;

    // every stop is sticky until reset and reset comes only once, so each run
    // closes the stream with one of the stopping cases, picked at random
    roll = $urandom_range(0, 5);
    case (roll)
      0: begin
        // count of an end record is not checked, the rest of the line is dropped
        closing = "end of file record";
        build_record(REC_EOF, 8'($urandom_range(0, 255)), 16'($urandom), -1, 1'b0);
      end
      1: begin
        // no colon at line start: bare newline, carriage return or any other byte
        closing = "missing colon";
        stray = 8'($urandom_range(0, 255));
        if (stray == CHAR_COLON || $urandom_range(0, 1) == 0) begin
          stray = ($urandom_range(0, 1) == 0) ? CHAR_NEWLINE : CHAR_CR;
        end
        line_buf.delete();
        line_buf.push_back(stray);
      end
      2: begin
        // record cut somewhere inside its digits by a newline or a non-hex byte
        closing = "bad digit";
        count = 8'($urandom_range(0, 6));
        build_record(REC_DATA, count, 16'($urandom), -1, 1'b0);
        cut = $urandom_range(1, 2 * (5 + count));
        while (line_buf.size() > cut) void'(line_buf.pop_back());
        stray = 8'($urandom_range(0, 255));
        while (is_hex_char(stray)) stray = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) stray = CHAR_NEWLINE;
        line_buf.push_back(stray);
      end
      3: begin
        closing = "unknown record type";
        build_record(8'($urandom_range(4, 255)), 8'($urandom_range(0, 4)),
                     16'($urandom), -1, 1'b0);
      end
      4: begin
        // segment record with any count other than two
        closing = "bad segment count";
        count = 8'($urandom_range(0, 255));
        if (count == SEG_COUNT) count = 8'h03;
        build_record(REC_SEGMENT, count, 16'($urandom), -1, 1'b0);
      end
      default: begin
        closing = "checksum error";
        build_record(($urandom_range(0, 1) == 0) ? REC_DATA : REC_START,
                     8'($urandom_range(0, 8)), 16'($urandom), -1, 1'b1);
      end
    endcase
    send_line();

    // the block must drop all of these silently
    repeat (AfterStop) send_char(8'($urandom_range(0, 255)));
    push <= 1'b0;

    // sample the checker's counters away from the clock edge
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("covered %0d characters over %0d lines, %0d result beats compared",
             chars_sent, lines_sent, checked);
    $display("stream closed by %s, followed by %0d characters to be dropped",
             closing, AfterStop);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
